// ===== rtl/nsfd_pkg.sv =====
package nsfd_pkg;

    typedef enum logic [1:0] {
        KIND_GGA  = 2'd0,
        KIND_VTG  = 2'd1,
        KIND_RMC  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    localparam int M_TIME   = 0;
    localparam int M_LAT    = 1;
    localparam int M_LON    = 2;
    localparam int M_SATS   = 3;
    localparam int M_ALT    = 4;
    localparam int M_COURSE = 5;
    localparam int M_SPEED  = 6;
    localparam int M_DATE   = 7;
    localparam int M_SATCHG = 8;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [24:0] NUM_CAP = 25'd1000001;
    localparam logic [30:0] LON_MAX = 31'd134217727;

    typedef struct packed {
        logic [1:0]  sentence_kind;
        logic [8:0]  fields_mask;
        logic [17:0] time_seconds;
        logic [26:0] latitude;
        logic [27:0] longitude;
        logic [6:0]  satellites;
        logic [20:0] altitude_dm;
        logic [9:0]  course_deg;
        logic [16:0] speed_dkmh;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [11:0] year;
    } res_t;

    function automatic logic [7:0] kind_letter(input logic [1:0] k, input logic [1:0] i);
        logic [7:0] r;
        r = 8'h00;
        case ({k, i})
            4'b00_00: r = "G";
            4'b00_01: r = "G";
            4'b00_10: r = "A";
            4'b01_00: r = "V";
            4'b01_01: r = "T";
            4'b01_10: r = "G";
            4'b10_00: r = "R";
            4'b10_01: r = "M";
            4'b10_10: r = "C";
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] time_w(input logic [4:0] p);
        logic [15:0] r;
        case (p)
            5'd0:    r = 16'd36000;
            5'd1:    r = 16'd3600;
            5'd2:    r = 16'd600;
            5'd3:    r = 16'd60;
            5'd4:    r = 16'd10;
            5'd5:    r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [22:0] lat_w(input logic [4:0] p);
        logic [22:0] r;
        case (p)
            5'd0:    r = 23'd6000000;
            5'd1:    r = 23'd600000;
            5'd2:    r = 23'd100000;
            5'd3:    r = 23'd10000;
            5'd5:    r = 23'd1000;
            5'd6:    r = 23'd100;
            5'd7:    r = 23'd10;
            5'd8:    r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

    function automatic logic [25:0] lon_w(input logic [4:0] p);
        logic [25:0] r;
        case (p)
            5'd0:    r = 26'd60000000;
            5'd1:    r = 26'd6000000;
            5'd2:    r = 26'd600000;
            5'd3:    r = 26'd100000;
            5'd4:    r = 26'd10000;
            5'd6:    r = 26'd1000;
            5'd7:    r = 26'd100;
            5'd8:    r = 26'd10;
            5'd9:    r = 26'd1;
            default: r = 26'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/nsfd_core.sv =====
module nsfd_core
    import nsfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_beat,
    input  logic [7:0]  rx_byte,
    input  logic [4:0]  utc_offset,
    output logic        res_valid,
    output res_t        res
);

    logic [4:0]         fi_reg, fi_next;
    logic [2:0]         hp_reg, hp_next;
    kind_t              kind_reg, kind_next;
    logic               ab_reg, ab_next;
    logic               hd_reg, hd_next;
    logic [4:0]         tl_reg, tl_next;
    logic [3:0]         nf_reg, nf_next;
    logic [18:0]        tacc_reg, tacc_next;
    logic signed [26:0] lat_reg, lat_next;
    logic signed [30:0] lon_reg, lon_next;
    logic signed [20:0] sm_reg, sm_next;
    logic [23:0]        dd_reg, dd_next;
    logic [8:0]         pm_reg, pm_next;
    logic [6:0]         ls_reg, ls_next;
    logic               pc_reg, pc_next;

    logic               do_hchar, do_hend, do_body, do_end, do_abort, skip;
    logic [7:0]         ch;
    logic [4:0]         pos;
    logic [3:0]         dg;
    logic               isdig, ws, dec;
    logic [1:0]         ph;
    logic [24:0]        a;
    logic signed [21:0] nv;
    logic signed [21:0] tv;
    logic [29:0]        c_prod;
    logic [6:0]         dayv, monv;

    always_comb begin
        fi_next = fi_reg; hp_next = hp_reg; kind_next = kind_reg; ab_next = ab_reg;
        hd_next = hd_reg; tl_next = tl_reg; nf_next = nf_reg; tacc_next = tacc_reg;
        lat_next = lat_reg; lon_next = lon_reg; sm_next = sm_reg; dd_next = dd_reg;
        pm_next = pm_reg; ls_next = ls_reg; pc_next = (rx_byte == CH_COMMA);
        do_hchar = 1'b0; do_hend = 1'b0; do_body = 1'b0; do_end = 1'b0;
        do_abort = 1'b0; skip = 1'b0; ch = rx_byte;
        pos = '0; dg = '0; isdig = 1'b0; ws = 1'b0; dec = 1'b0; ph = '0; a = '0;
        nv = '0; tv = '0; c_prod = '0; dayv = '0; monv = '0;
        res_valid = 1'b0; res = '0;

        if (rx_byte == CH_DOLLAR) begin
            if (!hd_reg) do_hend = 1'b1;
            else if (kind_reg != KIND_NONE && !ab_reg) do_end = 1'b1;
        end else if (!hd_reg) begin
            if (rx_byte == CH_COMMA || rx_byte == CH_STAR || rx_byte == 8'h00) begin
                do_hend = 1'b1;
                do_abort = (rx_byte == 8'h00);
            end else begin
                do_hchar = 1'b1;
            end
        end else if (kind_reg != KIND_NONE && !ab_reg) begin
            if (rx_byte == 8'h00) begin
                do_end = 1'b1;
                do_abort = 1'b1;
            end else if (rx_byte == CH_COMMA) begin
                do_body = pc_reg;
                ch = CH_SPACE;
                do_end = 1'b1;
            end else if (rx_byte == CH_STAR) begin
                do_end = 1'b1;
            end else begin
                do_body = 1'b1;
            end
        end

        if (do_hchar) begin
            if (hp_reg < 3'd7) hp_next = hp_reg + 3'd1;
            if (hp_reg == 3'd2) begin
                if (ch == kind_letter(KIND_GGA, 2'd0)) kind_next = KIND_GGA;
                else if (ch == kind_letter(KIND_VTG, 2'd0)) kind_next = KIND_VTG;
                else if (ch == kind_letter(KIND_RMC, 2'd0)) kind_next = KIND_RMC;
                else kind_next = KIND_NONE;
            end else if (hp_reg == 3'd3 || hp_reg == 3'd4) begin
                if (kind_reg != KIND_NONE &&
                    ch != kind_letter(kind_reg, hp_reg[1:0] - 2'd2))
                    kind_next = KIND_NONE;
            end else if (hp_reg >= 3'd5) begin
                kind_next = KIND_NONE;
            end
        end

        if (do_hend) begin
            if (hp_reg != 3'd5) kind_next = KIND_NONE;
            hd_next = 1'b1;
        end

        if (do_body) begin
            pos = tl_reg;
            if (tl_reg < 5'd31) tl_next = tl_reg + 5'd1;
            isdig = (ch >= "0" && ch <= "9");
            dg = isdig ? 4'(ch - "0") : 4'd0;
            ws = (ch == CH_SPACE) || (ch >= 8'd9 && ch <= 8'd13);
            if (kind_reg == KIND_GGA && fi_reg == 5'd0 && pos < 5'd6) begin
                tacc_next = tacc_reg + 19'(dg) * 19'(time_w(pos));
            end else if (kind_reg == KIND_GGA && fi_reg == 5'd1 && pos < 5'd10) begin
                lat_next = lat_reg + $signed({1'b0, 26'(dg) * 26'(lat_w(pos))});
            end else if (kind_reg == KIND_GGA && fi_reg == 5'd3 && pos < 5'd11) begin
                lon_next = lon_reg + $signed({1'b0, 30'(dg) * 30'(lon_w(pos))});
            end else if (kind_reg == KIND_GGA && pos == 5'd0 &&
                         ((fi_reg == 5'd2 && ch == CH_S) ||
                          (fi_reg == 5'd4 && ch == CH_W))) begin
                nf_next[0] = 1'b1;
            end else if ((kind_reg == KIND_GGA && (fi_reg == 5'd6 || fi_reg == 5'd8)) ||
                         (kind_reg == KIND_VTG && (fi_reg == 5'd0 || fi_reg == 5'd6))) begin
                dec = (kind_reg == KIND_VTG) || (fi_reg == 5'd8);
                a = (pos == 5'd0) ? 25'd0 : {4'd0, sm_reg};
                if (pos == 5'd0) sm_next = '0;
                ph = nf_reg[1:0];
                case (ph)
                    2'd0: begin
                        if (ws) begin
                            skip = 1'b1;
                        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                            if (ch == CH_MINUS) nf_next[2] = 1'b1;
                            ph = 2'd1;
                        end else if (isdig) begin
                            a = 25'(a * 25'd10) + (dec ? 25'(dg) * 25'd10 : 25'(dg));
                            ph = 2'd1;
                        end else if (ch == CH_DOT && dec) begin
                            ph = 2'd2;
                        end else begin
                            ph = 2'd3;
                        end
                    end
                    2'd1: begin
                        if (isdig) a = 25'(a * 25'd10) + (dec ? 25'(dg) * 25'd10 : 25'(dg));
                        else if (ch == CH_DOT && dec) ph = 2'd2;
                        else ph = 2'd3;
                    end
                    2'd2: begin
                        if (isdig) begin
                            if (!nf_reg[3]) begin
                                a = a + 25'(dg);
                                nf_next[3] = 1'b1;
                            end
                        end else begin
                            ph = 2'd3;
                        end
                    end
                    default: ;
                endcase
                if (!skip) begin
                    if (a > NUM_CAP) a = NUM_CAP;
                    sm_next = $signed(a[20:0]);
                    nf_next[1:0] = ph;
                end
            end else if (kind_reg == KIND_RMC && fi_reg == 5'd8 && pos < 5'd6) begin
                dd_next = dd_reg | (24'(dg) << {pos[2:0], 2'b00});
            end
        end

        if (do_end && tl_next != 5'd0) begin
            nv = nf_next[2] ? -22'(sm_next) : 22'(sm_next);
            case (kind_reg)
                KIND_GGA: begin
                    case (fi_reg)
                        5'd0: begin
                            tv = $signed({3'd0, tacc_next}) +
                                 22'($signed(utc_offset)) * 22'sd3600;
                            if (tv < 0) tv = '0;
                            if (tv > 22'sd262143) tv = 22'sd262143;
                            tacc_next = tv[18:0];
                            pm_next[M_TIME] = 1'b1;
                        end
                        5'd1: begin
                            if (tl_next != 5'd10) ab_next = 1'b1;
                            else pm_next[M_LAT] = 1'b1;
                        end
                        5'd2: if (nf_next[0]) lat_next = -lat_next;
                        5'd3: begin
                            if (tl_next != 5'd11) begin
                                ab_next = 1'b1;
                            end else begin
                                if (lon_next > $signed(LON_MAX)) lon_next = $signed(LON_MAX);
                                pm_next[M_LON] = 1'b1;
                            end
                        end
                        5'd4: if (nf_next[0]) lon_next = -lon_next;
                        5'd6: begin
                            if (nv < 0) nv = '0;
                            if (nv > 22'sd99) nv = 22'sd99;
                            if (nv[6:0] != ls_reg) pm_next[M_SATCHG] = 1'b1;
                            ls_next = nv[6:0];
                            pm_next[M_SATS] = 1'b1;
                        end
                        5'd8: begin
                            if (nv < -22'sd100000) nv = -22'sd100000;
                            if (nv > 22'sd1000000) nv = 22'sd1000000;
                            sm_next = nv[20:0];
                            pm_next[M_ALT] = 1'b1;
                        end
                        default: ;
                    endcase
                end
                KIND_VTG: begin
                    if (fi_reg == 5'd0) begin
                        c_prod = 30'(nv[13:0]) * 30'd52429;
                        if (nv < 0) tacc_next = '0;
                        else if (nv >= 22'sd10000) tacc_next = 19'd999;
                        else tacc_next = 19'(c_prod[29:19]);
                        pm_next[M_COURSE] = 1'b1;
                    end else if (fi_reg == 5'd6) begin
                        if (nv < 0) nv = '0;
                        if (nv > 22'sd99999) nv = 22'sd99999;
                        sm_next = nv[20:0];
                        pm_next[M_SPEED] = 1'b1;
                    end
                end
                KIND_RMC: if (fi_reg == 5'd8) pm_next[M_DATE] = 1'b1;
                default: ;
            endcase
            if (fi_reg < 5'd31) fi_next = fi_reg + 5'd1;
            tl_next = '0;
            nf_next = '0;
        end

        if (do_abort) ab_next = 1'b1;

        if (rx_byte == CH_DOLLAR) begin
            if (kind_next != KIND_NONE) begin
                res_valid = 1'b1;
                dayv = 7'(dd_next[3:0]) * 7'd10 + 7'(dd_next[7:4]);
                monv = 7'(dd_next[11:8]) * 7'd10 + 7'(dd_next[15:12]);
                if (dayv == 7'd0) dayv = 7'd1;
                if (monv == 7'd0) monv = 7'd1;
                res.sentence_kind = kind_next;
                res.fields_mask   = pm_next;
                res.time_seconds  = pm_next[M_TIME] ? tacc_next[17:0] : '0;
                res.latitude      = pm_next[M_LAT] ? lat_next : '0;
                res.longitude     = pm_next[M_LON] ? lon_next[27:0] : '0;
                res.satellites    = pm_next[M_SATS] ? ls_next : '0;
                res.altitude_dm   = pm_next[M_ALT] ? sm_next : '0;
                res.course_deg    = pm_next[M_COURSE] ? tacc_next[9:0] : '0;
                res.speed_dkmh    = pm_next[M_SPEED] ? sm_next[16:0] : '0;
                res.day           = pm_next[M_DATE] ? dayv : '0;
                res.month         = pm_next[M_DATE] ? monv : '0;
                res.year          = pm_next[M_DATE] ?
                                    12'd2000 + 12'(dd_next[19:16]) * 12'd10 +
                                    12'(dd_next[23:20]) : '0;
            end
            fi_next = '0; hp_next = '0; kind_next = KIND_NONE; ab_next = 1'b0;
            hd_next = 1'b0; tl_next = '0; nf_next = '0; tacc_next = '0;
            lat_next = '0; lon_next = '0; sm_next = '0; dd_next = '0; pm_next = '0;
            pc_next = 1'b0;
        end
        if (!in_beat) res_valid = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fi_reg <= '0; hp_reg <= '0; kind_reg <= KIND_NONE; ab_reg <= 1'b0;
            hd_reg <= 1'b1; tl_reg <= '0; nf_reg <= '0; tacc_reg <= '0;
            lat_reg <= '0; lon_reg <= '0; sm_reg <= '0; dd_reg <= '0; pm_reg <= '0;
            ls_reg <= 7'd127; pc_reg <= 1'b0;
        end else if (in_beat) begin
            fi_reg <= fi_next; hp_reg <= hp_next; kind_reg <= kind_next; ab_reg <= ab_next;
            hd_reg <= hd_next; tl_reg <= tl_next; nf_reg <= nf_next; tacc_reg <= tacc_next;
            lat_reg <= lat_next; lon_reg <= lon_next; sm_reg <= sm_next; dd_reg <= dd_next;
            pm_reg <= pm_next; ls_reg <= ls_next; pc_reg <= pc_next;
        end
    end

    a_none_no_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == KIND_NONE |-> pm_reg == '0) else $error("mask without sentence");
    a_hdr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !hd_reg |-> fi_reg == '0 && pm_reg == '0) else $error("fields during header");
    a_emit_dollar: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> in_beat && rx_byte == CH_DOLLAR) else $error("result without dollar");

endmodule

// ===== rtl/nsfd_out_buf.sv =====
module nsfd_out_buf
    import nsfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    logic m_valid_reg, skid_valid_reg;
    res_t m_res_reg, skid_res_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = m_valid_reg;
    assign out_res   = m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || out_ready) begin
            m_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end else if (in_valid) begin
            skid_res_reg <= in_res;
        end
    end

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg) else $error("skid holds data ahead of output");
    a_skid_only_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !out_ready))
        else $error("skid filled without stall");

endmodule

// ===== rtl/nmea_sentence_field_decoder_unit.sv =====
// NMEA 0183 GGA/VTG/RMC decoder. One received byte per s_ beat, accepted every
// cycle while s_tready is high; each byte is decoded combinationally between the
// parse state registers and the result register; the result of the '$' beat that
// closes a sentence is registered in the output stage, whose two entries keep
// s_tready high while one result waits. Results come only for GGA, VTG and RMC
// sentences. cfg_data (signed hours) may be written only while idle.
module nmea_sentence_field_decoder_unit
    import nsfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // fields_mask, time_seconds, latitude, longitude,
                                    // satellites, altitude_dm, course_deg, speed_dkmh,
                                    // day, month, year, zero pad
    output logic [1:0]   m_tuser,   // sentence_kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data   // utc_offset_hours
);

    logic [4:0] utc_offset_reg;
    logic       core_valid;
    res_t       core_res, buf_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) utc_offset_reg <= '0;
        else if (cfg_valid) utc_offset_reg <= cfg_data;
    end

    nsfd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_beat    (s_tvalid && s_tready),
        .rx_byte    (s_tdata),
        .utc_offset (utc_offset_reg),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    nsfd_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (core_valid),
        .in_res    (core_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (buf_res),
        .out_ready (m_tready)
    );

    assign m_tuser = buf_res.sentence_kind;
    assign m_tdata = {5'd0, buf_res.year, buf_res.month, buf_res.day, buf_res.speed_dkmh,
                      buf_res.course_deg, buf_res.altitude_dm, buf_res.satellites,
                      buf_res.longitude, buf_res.latitude, buf_res.time_seconds,
                      buf_res.fields_mask};

endmodule
